// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PBL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define PBL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/pbl_pkg.sv =====
// shared constants, codes and types of the point bin locator
package pbl_pkg;

    localparam int OP_W      = 2;
    localparam int SLOT_W    = 12;
    localparam int CNT_W     = 20;
    localparam int PC_W      = 12;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_BINS   = 4096;
    localparam int DEF_COORD_BITS = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_Y   = 2'd2;

    localparam int OUT_W = ((SLOT_W + CNT_W + 7) / 8) * 8;

    typedef struct packed {
        logic mul_first;
        logic mul_second;
    } t_mac_ctl;

endpackage

// ===== rtl/core/pbl_xprod.sv =====
// shared multiplier and sign test for the cross product
module pbl_xprod
    import pbl_pkg::*;
#(
    parameter int OPW = DEF_COORD_BITS + 1
) (
    input  logic                  i_clk,
    input  t_mac_ctl              i_ctl,
    input  logic signed [OPW-1:0] i_a,
    input  logic signed [OPW-1:0] i_b,
    output logic                  o_pos
);

    logic signed [2*OPW-1:0] w_prod;
    logic signed [2*OPW-1:0] r_p1;
    logic signed [2*OPW-1:0] r_p2;
    logic signed [2*OPW:0]   w_diff;

    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_first) begin
            r_p1 <= w_prod;
        end
        if (i_ctl.mul_second) begin
            r_p2 <= w_prod;
        end
    end

    assign w_diff = {r_p1[2*OPW-1], r_p1} - {r_p2[2*OPW-1], r_p2};
    assign o_pos  = !w_diff[2*OPW] && (|w_diff);

endmodule

// ===== rtl/core/point_bin_locator_histogram.sv =====
// top level of the point bin locator with per-bin hit histogram
// channels: one request in on the s_axis group, one result out on the m_axis group for
// every request; a request is taken when tvalid and tready are both high.
// requests: load a partition, locate a point, read a bin count, clear all counts.
// configuration: plain write port, taken at any edge with i_cfg_we high; the user
// must write it only while idle, the block itself does not enforce this.
// one request at a time: tready is high only while the sequencer is idle.
// locate: each binary search probe goes through the single shared multiplier (segment
// read, two products, sign test), at most ceil(log2(partition_count + 1)) probes.
// load goes straight to its result, read via a count read; clear sweeps the count memory.
// reset: synchronous active low; it clears the registers and then runs a clearing pass
// over the count memory, during which no request is taken.
// stall: the result waits in the output register; one more request is taken meanwhile,
// and its result is held inside until the output register frees up.
module point_bin_locator_histogram
    import pbl_pkg::*;
#(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int IN_W       = ((OP_W + SLOT_W + 4 * COORD_BITS + 7) / 8) * 8,
    parameter int CFG_W      = (COORD_BITS > PC_W) ? COORD_BITS : PC_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // opcode, slot, upper_x, lower_x, point_x, point_y
    input  logic [IN_W-1:0]      i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // bin, count
    output logic [OUT_W-1:0]     o_m_axis_tdata
);

    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int PART_SLOTS = MAX_BINS - 1;
    localparam int EXT_W      = ((BIN_W > SLOT_W) ? BIN_W : SLOT_W) + 1;
    localparam int OPW        = COORD_BITS + 1;
    localparam int SEG_W      = 2 * COORD_BITS;

    localparam int F_SLOT = OP_W;
    localparam int F_UX   = F_SLOT + SLOT_W;
    localparam int F_LX   = F_UX + COORD_BITS;
    localparam int F_PX   = F_LX + COORD_BITS;
    localparam int F_PY   = F_PX + COORD_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_PROBE = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_CRD   = 4'd6;
    localparam logic [3:0] S_CWR   = 4'd7;
    localparam logic [3:0] S_RDRES = 4'd8;
    localparam logic [3:0] S_PUSH  = 4'd9;

    logic [3:0]                   r_state;
    logic [PC_W-1:0]              r_part_count;
    logic signed [COORD_BITS-1:0] r_top_y;
    logic signed [COORD_BITS-1:0] r_bottom_y;
    logic [BIN_W-1:0]             r_lo;
    logic [BIN_W-1:0]             r_hi;
    logic [BIN_W-1:0]             r_mid;
    logic [BIN_W-1:0]             r_caddr;
    logic [BIN_W-1:0]             r_clr;
    logic                         r_clr_resp;
    logic                         r_in_range;
    logic                         r_is_locate;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [OPW-1:0]        r_pyb;
    logic signed [OPW-1:0]        r_dy;
    logic [SLOT_W-1:0]            r_res_bin;
    logic [CNT_W-1:0]             r_res_cnt;
    logic                         r_m_valid;
    logic [OUT_W-1:0]             r_m_data;
    logic [SEG_W-1:0]             r_seg_q;
    logic [CNT_W-1:0]             r_cnt_q;

    logic [SEG_W-1:0] seg_mem [PART_SLOTS];
    logic [CNT_W-1:0] cnt_mem [MAX_BINS];

    logic                         w_accept;
    logic [OP_W-1:0]              w_op;
    logic [EXT_W-1:0]             w_slot_ext;
    logic signed [COORD_BITS-1:0] w_ux;
    logic signed [COORD_BITS-1:0] w_lx;
    logic signed [COORD_BITS-1:0] w_px;
    logic signed [COORD_BITS-1:0] w_py;
    logic [EXT_W-1:0]             w_pc_ext;
    logic [EXT_W-1:0]             w_n;
    logic [BIN_W:0]               w_sum;
    logic [BIN_W-1:0]             w_mid;
    logic                         w_load_we;
    logic                         w_cnt_we;
    logic [BIN_W-1:0]             w_cnt_wa;
    logic [CNT_W-1:0]             w_cnt_wd;
    logic [CNT_W-1:0]             w_cnt_inc;
    logic signed [COORD_BITS-1:0] w_seg_ux;
    logic signed [COORD_BITS-1:0] w_seg_lx;
    logic signed [OPW-1:0]        w_mul_a;
    logic signed [OPW-1:0]        w_mul_b;
    t_mac_ctl                     w_mac_ctl;
    logic                         w_pos;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op       = i_s_axis_tdata[OP_W-1:0];
    assign w_slot_ext = EXT_W'(i_s_axis_tdata[F_SLOT +: SLOT_W]);
    assign w_ux       = i_s_axis_tdata[F_UX +: COORD_BITS];
    assign w_lx       = i_s_axis_tdata[F_LX +: COORD_BITS];
    assign w_px       = i_s_axis_tdata[F_PX +: COORD_BITS];
    assign w_py       = i_s_axis_tdata[F_PY +: COORD_BITS];

    assign w_pc_ext = EXT_W'(r_part_count);
    assign w_n      = (w_pc_ext > EXT_W'(PART_SLOTS)) ? EXT_W'(PART_SLOTS) : w_pc_ext;
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[BIN_W:1];

    assign w_load_we = w_accept && (w_op == OP_LOAD) && (w_slot_ext < EXT_W'(PART_SLOTS));

    assign w_cnt_inc = (r_cnt_q == CNT_MAX) ? r_cnt_q : r_cnt_q + 1'b1;
    assign w_cnt_we  = (r_state == S_CLR) || (r_state == S_CWR);
    assign w_cnt_wa  = (r_state == S_CLR) ? r_clr : r_caddr;
    assign w_cnt_wd  = (r_state == S_CLR) ? '0 : w_cnt_inc;

    assign w_seg_ux = r_seg_q[COORD_BITS-1:0];
    assign w_seg_lx = r_seg_q[SEG_W-1:COORD_BITS];

    assign w_mac_ctl.mul_first  = (r_state == S_MUL1);
    assign w_mac_ctl.mul_second = (r_state == S_MUL2);

    always_comb begin
        if (r_state == S_MUL1) begin
            w_mul_a = {w_seg_ux[COORD_BITS-1], w_seg_ux} - {w_seg_lx[COORD_BITS-1], w_seg_lx};
            w_mul_b = r_pyb;
        end else begin
            w_mul_a = {r_px[COORD_BITS-1], r_px} - {w_seg_lx[COORD_BITS-1], w_seg_lx};
            w_mul_b = r_dy;
        end
    end

    pbl_xprod #(
        .OPW (OPW)
    ) u_xprod (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_pos (w_pos)
    );

    // segment store
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            seg_mem[w_slot_ext[BIN_W-1:0]] <= {w_lx, w_ux};
        end
        r_seg_q <= seg_mem[w_mid];
    end

    // bin count store
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            cnt_mem[w_cnt_wa] <= w_cnt_wd;
        end
        r_cnt_q <= cnt_mem[r_caddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_count <= '0;
            r_top_y      <= '0;
            r_bottom_y   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PART_COUNT: r_part_count <= i_cfg_data[PC_W-1:0];
                REG_TOP_Y:      r_top_y      <= i_cfg_data[COORD_BITS-1:0];
                REG_BOTTOM_Y:   r_bottom_y   <= i_cfg_data[COORD_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // payload of the request in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px       <= w_px;
            r_pyb      <= {w_py[COORD_BITS-1], w_py} - {r_bottom_y[COORD_BITS-1], r_bottom_y};
            r_dy       <= {r_top_y[COORD_BITS-1], r_top_y}
                          - {r_bottom_y[COORD_BITS-1], r_bottom_y};
            r_in_range <= (w_slot_ext < EXT_W'(MAX_BINS));
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_clr_resp <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (r_state == S_PUSH && (!r_m_valid || i_m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_bin <= (w_op == OP_READ) ? w_slot_ext[SLOT_W-1:0] : '0;
                        r_res_cnt <= '0;
                        case (w_op)
                            OP_LOAD: begin
                                r_state <= S_PUSH;
                            end
                            OP_LOCATE: begin
                                r_lo    <= '0;
                                r_hi    <= w_n[BIN_W-1:0];
                                r_state <= S_PROBE;
                            end
                            OP_READ: begin
                                r_caddr <= w_slot_ext[BIN_W-1:0];
                                r_state <= S_CRD;
                            end
                            default: begin
                                r_clr      <= '0;
                                r_clr_resp <= 1'b1;
                                r_state    <= S_CLR;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BIN_W'(MAX_BINS - 1)) begin
                        r_clr_resp <= 1'b0;
                        r_state    <= r_clr_resp ? S_PUSH : S_IDLE;
                    end
                end
                S_PROBE: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= S_MUL1;
                    end else begin
                        r_caddr <= r_hi;
                        r_state <= S_CRD;
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_pos) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid + 1'b1;
                    end
                    r_state <= S_PROBE;
                end
                S_CRD: begin
                    r_state <= r_is_locate ? S_CWR : S_RDRES;
                end
                S_CWR: begin
                    r_res_bin <= SLOT_W'(EXT_W'(r_caddr));
                    r_res_cnt <= w_cnt_inc;
                    r_state   <= S_PUSH;
                end
                S_RDRES: begin
                    r_res_cnt <= r_in_range ? r_cnt_q : '0;
                    r_state   <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_data <= OUT_W'({r_res_cnt, r_res_bin});
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_locate <= 1'b0;
        end else if (w_accept) begin
            r_is_locate <= (w_op == OP_LOCATE);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

// ===== rtl/core/pbl_checker.sv =====
// port-level checker for the point bin locator, bound to the top level
`include "assert_macros.svh"

module pbl_checker
    import pbl_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    `PBL_ASSERT_NEXT(a_out_valid_holds, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `PBL_ASSERT_NEXT(a_out_data_holds, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata))
    `PBL_ASSERT_IMPL(a_clear_after_reset, $past(!i_rst_n), !o_s_axis_tready && !o_m_axis_tvalid)
    `PBL_ASSERT_NEXT(a_one_in_flight, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

bind point_bin_locator_histogram pbl_checker u_pbl_checker (.*);
